FILE: hdl/tfl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Timestamp frame lookup package
// Shared types and constants for the frame timestamp table.
// ----------------------------------------------------------------------------
package tfl_pkg;

   localparam int TFL_DEPTH_DEFAULT = 4096;
   localparam int FRAME_INDEX_W     = 12;
   localparam int STAMP_W           = 64;

   // stamps are kept with the sign bit flipped so unsigned order is signed order
   localparam logic [STAMP_W-1:0] SIGN_BIAS = {1'b1, {(STAMP_W-1){1'b0}}};

   typedef enum logic [1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_APPEND  = 2'd1,
      CMD_EXACT   = 2'd2,
      CMD_CLOSEST = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_ORDER     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PROBE,
      S_SKIP,
      S_PRED,
      S_PUSH
   } state_type;

   typedef struct packed {
      cmd_type             command;
      logic signed [63:0]  stamp;
      logic                hide_flag;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic [FRAME_INDEX_W-1:0]   frame_index;
   } rsp_type;

   typedef struct packed {
      logic                hidden;
      logic [STAMP_W-1:0]  stamp;
   } entry_type;

endpackage
`default_nettype wire

FILE: hdl/timestamp_frame_lookup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Timestamp frame lookup
// Table of frame timestamps with hidden marks; append, clear, exact and
// closest lookup by lower-bound binary search over a 1R1W table RAM.
//
// Requests come in on req_valid/req_ready with a req_type payload; exactly
// one response per request leaves on rsp_valid/rsp_ready as rsp_type.
// Clear and append: the result is registered and then passes through S_PUSH.
// Lookups run one binary-search probe per cycle on the table RAM (one read
// per cycle, registered read data), then one S_SKIP step per hidden equal
// entry skipped, plus one predecessor read in S_PRED for closest lookups.
// One request is in flight at a time; the next request is taken once the
// current result has moved to the response register, so a new request can
// be accepted while an earlier response still waits for rsp_ready.
// A stalled receiver holds the response register and the finished result
// behind it; no result is dropped.
// Reset empties the table (entry count zero) at once; RAM contents are not
// touched and no clearing pass is needed.
// ----------------------------------------------------------------------------
module timestamp_frame_lookup
   import tfl_pkg::*;
#(
   parameter int TABLE_DEPTH = TFL_DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW    = $clog2(TABLE_DEPTH + 1);
   localparam int EXT_W = (CW > FRAME_INDEX_W) ? CW : FRAME_INDEX_W;

   function automatic logic [FRAME_INDEX_W-1:0] to_index(input logic [CW-1:0] v);
      logic [EXT_W-1:0] e;
      e = EXT_W'(v);
      return e[FRAME_INDEX_W-1:0];
   endfunction

   // table RAM
   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;
   logic      rd_en;
   logic [AW-1:0] rd_addr;
   logic      wr_en;
   logic [AW-1:0] wr_addr;
   entry_type wr_data;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    lo_ff, lo_in;
   logic [CW-1:0]    hi_ff, hi_in;
   logic [CW-1:0]    mid_ff, mid_in;
   logic [STAMP_W-1:0] key_ff, key_in;
   logic [STAMP_W-1:0] last_ff, last_in;
   logic [STAMP_W-1:0] after_ff, after_in;
   cmd_type          cmd_ff, cmd_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_ff;
   logic             rsp_valid_ff;
   logic             load_rsp;

   logic [STAMP_W-1:0] req_key;
   logic [CW-1:0]    half_count;
   logic             probe_below;
   logic [CW-1:0]    lo_n, hi_n, span_n, mid_n;
   logic [CW-1:0]    lo_plus, lo_minus;
   logic             skip_hit;
   logic [STAMP_W-1:0] d_after, d_before;
   rsp_type          past_end_res;

   assign req_key     = req_payload.stamp ^ SIGN_BIAS;
   assign half_count  = count_ff >> 1;
   assign probe_below = rd_data_ff.stamp < key_ff;
   assign lo_n        = probe_below ? mid_ff + CW'(1) : lo_ff;
   assign hi_n        = probe_below ? hi_ff : mid_ff;
   assign span_n      = hi_n - lo_n;
   assign mid_n       = lo_n + (span_n >> 1);
   assign lo_plus     = lo_ff + CW'(1);
   assign lo_minus    = lo_ff - CW'(1);
   assign skip_hit    = rd_data_ff.hidden && (rd_data_ff.stamp == key_ff);
   assign d_after     = after_ff - key_ff;
   assign d_before    = key_ff - rd_data_ff.stamp;

   always_comb begin
      if (cmd_ff == CMD_CLOSEST) begin
         past_end_res = '{status: ST_OK, frame_index: to_index(count_ff - CW'(1))};
      end else begin
         past_end_res = '{status: ST_NOT_FOUND, frame_index: '0};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      key_in    = key_ff;
      last_in   = last_ff;
      after_in  = after_ff;
      cmd_in    = cmd_ff;
      res_in    = res_ff;
      rd_en     = 1'b0;
      rd_addr   = mid_ff[AW-1:0];
      wr_en     = 1'b0;
      wr_addr   = count_ff[AW-1:0];
      wr_data   = '{hidden: req_payload.hide_flag, stamp: req_key};
      req_ready = 1'b0;
      load_rsp  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_in = req_key;
               cmd_in = req_payload.command;
               case (req_payload.command)
                  CMD_CLEAR: begin
                     count_in = '0;
                     res_in   = '{status: ST_OK, frame_index: '0};
                     state_in = S_PUSH;
                  end
                  CMD_APPEND: begin
                     if (count_ff == CW'(TABLE_DEPTH)) begin
                        res_in = '{status: ST_FULL, frame_index: '0};
                     end else if (count_ff != '0 && req_key < last_ff) begin
                        res_in = '{status: ST_ORDER, frame_index: '0};
                     end else begin
                        wr_en    = 1'b1;
                        last_in  = req_key;
                        count_in = count_ff + CW'(1);
                        res_in   = '{status: ST_OK, frame_index: to_index(count_ff)};
                     end
                     state_in = S_PUSH;
                  end
                  default: begin
                     if (count_ff == '0) begin
                        res_in   = '{status: ST_NOT_FOUND, frame_index: '0};
                        state_in = S_PUSH;
                     end else begin
                        lo_in    = '0;
                        hi_in    = count_ff;
                        mid_in   = half_count;
                        rd_en    = 1'b1;
                        rd_addr  = half_count[AW-1:0];
                        state_in = S_PROBE;
                     end
                  end
               endcase
            end
         end

         S_PROBE: begin
            lo_in  = lo_n;
            hi_in  = hi_n;
            mid_in = mid_n;
            if (lo_n < hi_n) begin
               rd_en   = 1'b1;
               rd_addr = mid_n[AW-1:0];
            end else if (lo_n < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = lo_n[AW-1:0];
               state_in = S_SKIP;
            end else begin
               res_in   = past_end_res;
               state_in = S_PUSH;
            end
         end

         S_SKIP: begin
            if (skip_hit) begin
               lo_in = lo_plus;
               if (lo_plus < count_ff) begin
                  rd_en   = 1'b1;
                  rd_addr = lo_plus[AW-1:0];
               end else begin
                  res_in   = past_end_res;
                  state_in = S_PUSH;
               end
            end else if (cmd_ff == CMD_EXACT) begin
               if (rd_data_ff.stamp == key_ff) begin
                  res_in = '{status: ST_OK, frame_index: to_index(lo_ff)};
               end else begin
                  res_in = '{status: ST_NOT_FOUND, frame_index: '0};
               end
               state_in = S_PUSH;
            end else if (lo_ff == '0) begin
               res_in   = '{status: ST_OK, frame_index: '0};
               state_in = S_PUSH;
            end else begin
               after_in = rd_data_ff.stamp;
               rd_en    = 1'b1;
               rd_addr  = lo_minus[AW-1:0];
               state_in = S_PRED;
            end
         end

         S_PRED: begin
            // ties go to the later entry
            if (d_after <= d_before) begin
               res_in = '{status: ST_OK, frame_index: to_index(lo_ff)};
            end else begin
               res_in = '{status: ST_OK, frame_index: to_index(lo_minus)};
            end
            state_in = S_PUSH;
         end

         S_PUSH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      key_ff   <= key_in;
      last_ff  <= last_in;
      after_ff <= after_in;
      cmd_ff   <= cmd_in;
      res_ff   <= res_in;
      if (load_rsp) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

FILE: tb/timestamp_frame_lookup_tb.sv
// ----------------------------------------------------------------------------
// Timestamp frame lookup testbench
// Drives clear, append, exact and closest requests through the valid/ready
// request channel and checks every response against a behavioral model of
// the frame table kept in the bench. Covers empty tables, hidden
// duplicates, ordering rejects, 65-bit distances, distance ties and a long response
// stall, followed by randomized well-formed table sessions with some noise.
// ----------------------------------------------------------------------------
module timestamp_frame_lookup_tb;
   import tfl_pkg::*;

   localparam int TBL_DEPTH       = TFL_DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS    = 420;
   localparam int QUIET_LIMIT     = 2000;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 40;
   localparam logic signed [63:0] STAMP_MIN = {1'b1, 63'b0};
   localparam logic signed [63:0] STAMP_MAX = {1'b0, {63{1'b1}}};

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // bench copy of the frame table
   logic signed [63:0] stamp_tbl [TBL_DEPTH];
   bit                 hidden_tbl [TBL_DEPTH];
   int unsigned        entry_cnt = 0;

   rsp_type pending_rsp [$];
   int      mismatch_count = 0;
   int      quiet_cycles   = 0;
   bit      req_back_to_back = 1'b0;
   bit      rsp_back_to_back = 1'b0;
   bit      hold_rsp         = 1'b0;

   timestamp_frame_lookup #(.TABLE_DEPTH(TBL_DEPTH)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #6 clock = ~clock;

   function automatic int draw_gap(input bit back_to_back);
      if (back_to_back) return 0;
      return $urandom_range(0, 12);
   endfunction

   function automatic logic signed [63:0] rand_stamp();
      return {$urandom, $urandom};
   endfunction

   // applies one request to the bench table and returns the response it owes
   function automatic rsp_type table_apply(input req_type r);
      rsp_type            o;
      logic signed [63:0] key;
      int unsigned        pos;
      int unsigned        last;
      logic [64:0]        d_after;
      logic [64:0]        d_before;
      key = r.stamp;
      o.status = ST_OK;
      o.frame_index = '0;
      case (r.command)
         CMD_CLEAR: begin
            entry_cnt = 0;
         end
         CMD_APPEND: begin
            if (entry_cnt >= TBL_DEPTH) begin
               o.status = ST_FULL;
            end else if (entry_cnt > 0 && key < stamp_tbl[entry_cnt-1]) begin
               o.status = ST_ORDER;
            end else begin
               stamp_tbl[entry_cnt]  = key;
               hidden_tbl[entry_cnt] = r.hide_flag;
               o.frame_index = entry_cnt[FRAME_INDEX_W-1:0];
               entry_cnt++;
            end
         end
         default: begin
            if (entry_cnt == 0) begin
               o.status = ST_NOT_FOUND;
            end else begin
               pos = 0;
               while (pos < entry_cnt && stamp_tbl[pos] < key) pos++;
               // hidden frames with the same stamp are passed over
               while (pos < entry_cnt && hidden_tbl[pos] && stamp_tbl[pos] == key) pos++;
               last = entry_cnt - 1;
               if (r.command == CMD_EXACT) begin
                  if (pos < entry_cnt && stamp_tbl[pos] == key)
                     o.frame_index = pos[FRAME_INDEX_W-1:0];
                  else
                     o.status = ST_NOT_FOUND;
               end else if (pos >= entry_cnt) begin
                  o.frame_index = last[FRAME_INDEX_W-1:0];
               end else if (pos == 0) begin
                  o.frame_index = '0;
               end else begin
                  // sign-extended to 65 bits, both distances are nonnegative
                  d_after  = {stamp_tbl[pos][63], stamp_tbl[pos]} - {key[63], key};
                  d_before = {key[63], key} - {stamp_tbl[pos-1][63], stamp_tbl[pos-1]};
                  if (d_after <= d_before)
                     o.frame_index = pos[FRAME_INDEX_W-1:0];
                  else
                     o.frame_index = FRAME_INDEX_W'(pos - 1);
               end
            end
         end
      endcase
      return o;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR: %s", msg);
      mismatch_count++;
   endtask

   task automatic send_request(input cmd_type cmd, input logic signed [63:0] stamp,
                               input logic hide);
      req_type r;
      int      gap;
      rsp_type owed;
      r.command   = cmd;
      r.stamp     = stamp;
      r.hide_flag = hide;
      gap = draw_gap(req_back_to_back);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      owed = table_apply(r);
      pending_rsp = {pending_rsp, owed};
   endtask

   // response side: random stalls, plus one long hold on request
   initial begin : rsp_side
      int gap;
      bit held;
      held = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (hold_rsp && !held) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end
         gap = draw_gap(rsp_back_to_back);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch($sformatf("response with none pending: status %0d index %0d",
                                      rsp_payload.status, rsp_payload.frame_index));
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_payload.status !== want.status)
               report_mismatch($sformatf("status: got %0d, want %0d",
                                         rsp_payload.status, want.status));
            if (rsp_payload.frame_index !== want.frame_index)
               report_mismatch($sformatf("frame_index: got %0d, want %0d",
                                         rsp_payload.frame_index, want.frame_index));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timestamp_frame_lookup regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // empty table, hidden duplicates at both ends, ordering reject, ties
   task automatic test_directed_cases();
      send_request(CMD_CLEAR, 0, 1'b0);
      send_request(CMD_EXACT, 0, 1'b0);
      send_request(CMD_CLOSEST, 0, 1'b0);
      send_request(CMD_APPEND, STAMP_MIN, 1'b1);
      send_request(CMD_APPEND, STAMP_MIN, 1'b0);
      send_request(CMD_APPEND, 0, 1'b0);
      send_request(CMD_APPEND, 100, 1'b0);
      send_request(CMD_APPEND, 100, 1'b1);
      send_request(CMD_APPEND, STAMP_MAX, 1'b1);
      send_request(CMD_APPEND, STAMP_MAX, 1'b1);
      send_request(CMD_APPEND, 50, 1'b0);
      send_request(CMD_EXACT, STAMP_MIN, 1'b0);
      send_request(CMD_EXACT, STAMP_MAX, 1'b0);
      send_request(CMD_CLOSEST, STAMP_MAX, 1'b0);
      send_request(CMD_CLOSEST, 50, 1'b0);
      send_request(CMD_CLOSEST, STAMP_MIN, 1'b0);
      send_request(CMD_CLOSEST, -1, 1'b0);
      send_request(CMD_EXACT, 100, 1'b1);
      send_request(CMD_APPEND, STAMP_MAX, 1'b0);
      send_request(CMD_EXACT, STAMP_MAX, 1'b0);
      send_request(CMD_CLEAR, 0, 1'b0);
      send_request(CMD_EXACT, 0, 1'b0);
      send_request(CMD_APPEND, 7, 1'b0);
   endtask

   // distances near 2^63 need the extra bit
   task automatic test_wide_distances();
      send_request(CMD_CLEAR, 0, 1'b0);
      send_request(CMD_APPEND, STAMP_MIN, 1'b0);
      send_request(CMD_APPEND, STAMP_MAX, 1'b0);
      send_request(CMD_CLOSEST, 0, 1'b0);
      send_request(CMD_CLOSEST, -1, 1'b0);
   endtask

   task automatic test_response_stall();
      int      i;
      cmd_type cmd;
      send_request(CMD_CLEAR, 0, 1'b0);
      for (i = 0; i < 8; i++) send_request(CMD_APPEND, i * 10, 1'($urandom_range(0, 1)));
      hold_rsp = 1'b1;
      req_back_to_back = 1'b1;
      for (i = 0; i < 24; i++) begin
         cmd = (i % 2) ? CMD_CLOSEST : CMD_EXACT;
         send_request(cmd, $urandom_range(0, 80), 1'($urandom_range(0, 1)));
      end
      req_back_to_back = 1'b0;
   endtask

   task automatic test_random_sequences();
      int                 sent;
      int                 n_app;
      int                 n_look;
      int unsigned        k;
      logic signed [63:0] prev;
      logic signed [63:0] s;
      logic [63:0]        step;
      logic [64:0]        acc;
      cmd_type            cmd;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         req_back_to_back = ($urandom_range(0, 5) == 0);
         rsp_back_to_back = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 3) != 0) begin
            send_request(CMD_CLEAR, rand_stamp(), 1'($urandom_range(0, 1)));
            sent++;
         end
         n_app = $urandom_range(1, 40);
         repeat (n_app) begin
            if (entry_cnt == 0) begin
               case ($urandom_range(0, 3))
                  0: s = rand_stamp();
                  1: s = $signed(64'($urandom_range(0, 2000))) - 1000;
                  2: s = STAMP_MIN;
                  default: s = STAMP_MAX - $urandom_range(0, 100);
               endcase
            end else begin
               prev = stamp_tbl[entry_cnt-1];
               if ($urandom_range(0, 9) == 0 && prev > STAMP_MIN + 1000) begin
                  s = prev - $urandom_range(1, 1000);
               end else begin
                  case ($urandom_range(0, 3))
                     0: step = '0;
                     1: step = $urandom_range(1, 16);
                     2: step = {32'b0, $urandom};
                     default: step = {$urandom, $urandom} >> $urandom_range(1, 63);
                  endcase
                  acc = {prev[63], prev} + {1'b0, step};
                  s = (acc[64] != acc[63]) ? STAMP_MAX : acc[63:0];
               end
            end
            send_request(CMD_APPEND, s, ($urandom_range(0, 3) == 0));
            sent++;
         end
         n_look = $urandom_range(4, 30);
         repeat (n_look) begin
            cmd = $urandom_range(0, 1) ? CMD_EXACT : CMD_CLOSEST;
            if (entry_cnt == 0) begin
               s = rand_stamp();
            end else begin
               k = $urandom_range(0, entry_cnt - 1);
               case ($urandom_range(0, 6))
                  0, 1: s = stamp_tbl[k];
                  2: s = stamp_tbl[k] + 1;
                  3: s = stamp_tbl[k] - 1;
                  4: begin
                     // midpoint of neighbors gives distance ties or near-ties
                     if (k + 1 < entry_cnt) begin
                        acc = {stamp_tbl[k][63], stamp_tbl[k]}
                              + {stamp_tbl[k+1][63], stamp_tbl[k+1]};
                        s = acc[64:1];
                     end else begin
                        s = stamp_tbl[k];
                     end
                  end
                  5: s = rand_stamp();
                  default: begin
                     cmd = cmd_type'($urandom_range(0, 3));
                     s = rand_stamp();
                  end
               endcase
            end
            send_request(cmd, s, 1'($urandom_range(0, 1)));
            sent++;
         end
      end
      req_back_to_back = 1'b0;
      rsp_back_to_back = 1'b0;
   endtask

   initial begin : main_seq
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_wide_distances();
      test_response_stall();
      test_random_sequences();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("timestamp_frame_lookup regression: pass");
      else
         $display("timestamp_frame_lookup regression: fail");
      $finish;
   end

endmodule
